// File: sv/art_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// art_pkg
// Shared types and constants of the address range tracker.
// ----------------------------------------------------------------------------
package art_pkg;

  localparam int unsigned MAX_RANGES = 64;
  localparam int unsigned IDX_W = $clog2(MAX_RANGES);
  localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);
  localparam int unsigned ITER_LIMIT = MAX_RANGES + 1;
  localparam int unsigned ITER_W = $clog2(ITER_LIMIT + 2);

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OVERLAP  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_CUT      = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam logic [1:0] REQ_REG   = 2'd0;
  localparam logic [1:0] REQ_UNREG = 2'd1;
  localparam logic [1:0] REQ_COVER = 2'd2;
  localparam logic [1:0] REQ_FIND  = 2'd3;

  localparam logic CFG_PAGE  = 1'b0;
  localparam logic CFG_ALIGN = 1'b1;

  // one table entry as stored in the memory
  typedef struct packed {
    logic [63:0] base;
    logic [63:0] last;
    logic        kind;
    logic [31:0] region;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_LOOK_W, S_DECIDE, S_SHIFT_RD, S_SHIFT_WR,
    S_INS_RD, S_INS_WR, S_DONE
  } state_t;

endpackage

// File: sv/address_range_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_range_tracker
// Sorted table of non-overlapping address ranges with register, unregister,
// coverage and find requests.
// ----------------------------------------------------------------------------
// Usage:
//   in_tdata  : req_type, range_base, range_length, map_kind, region_number.
//   out_tdata : status, covered, found, found_base, found_end, found_kind,
//               found_region. One result per request.
//   cfg_*     : register 0 page_size_log2, register 1 align_log2; write only
//               while no request is in flight.
// Timing: one request at a time. A lookup reads the entry memory one entry
//   at a time (read issued in S_LOOK, checked in S_LOOK_W); inserts and
//   removals move entries one at a time. An unregister or coverage repeats
//   a lookup per piece.
// Reset clears the entry count and sets both cfg registers to 12; no clearing pass is run.
// A stalled receiver holds the result in the output register; the next
// request is taken once the result has left.
// ----------------------------------------------------------------------------
module address_range_tracker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // req_type[1:0], range_base[65:2], range_length[129:66], map_kind[130],
  // region_number[162:131], zero pad to 168
  input  logic [167:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], covered[3], found[4], found_base[68:5], found_end[132:69],
  // found_kind[133], found_region[165:134], zero pad to 168
  output logic [167:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [4:0]   cfg_data
);

  localparam int unsigned IW = art_pkg::IDX_W;
  localparam int unsigned CW = art_pkg::CNT_W;

  art_pkg::state_t state_r, state_nxt;
  logic [4:0]  page_r, align_r;
  logic [1:0]  req_r, req_nxt;
  logic [63:0] b_r, b_nxt, e_r, e_nxt, len_r, len_nxt;
  logic        kind_r, kind_nxt;
  logic [31:0] reg_r, reg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] i_r, i_nxt;      // scan / shift index
  logic [CW-1:0] k_r, k_nxt;      // found slot
  logic [art_pkg::ITER_W-1:0] it_r, it_nxt;
  art_pkg::entry_t ent_r, ent_nxt;   // entry being cut
  logic        tail_r, tail_nxt;    // tail piece pending insert
  art_pkg::entry_t ins_r, ins_nxt;  // entry to insert
  logic        ins_up_r, ins_up_nxt; // insert shifts up, else remove shifts down
  logic        out_v_r, out_v_nxt;
  logic [167:0] out_d_r, out_d_nxt;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  art_pkg::entry_t wdata, rdata;

  art_ram u_ram (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
                 .raddr(raddr), .rdata(rdata));

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == art_pkg::S_IDLE) && !out_v_r;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  // overlap and early stop on the entry just read
  logic hit, past;
  assign hit  = (b_r < rdata.last) && ((b_r >= rdata.base) || (e_r > rdata.base));
  assign past = b_r < rdata.base;

  logic [63:0] pmask, amask, rlen;
  logic        rlen_c;
  assign pmask = (64'd1 << page_r) - 64'd1;
  assign amask = (64'd1 << align_r) - 64'd1;

  function automatic logic [167:0] pack_out(logic [2:0] st, logic cov, logic fnd,
                                            art_pkg::entry_t en);
    pack_out = {2'b00, en.region, en.kind, en.last, en.base, fnd, cov, st};
  endfunction

  always_comb begin
    state_nxt = state_r; req_nxt = req_r; b_nxt = b_r; e_nxt = e_r;
    len_nxt = len_r; kind_nxt = kind_r; reg_nxt = reg_r; cnt_nxt = cnt_r;
    i_nxt = i_r; k_nxt = k_r; it_nxt = it_r; ent_nxt = ent_r; tail_nxt = tail_r;
    ins_nxt = ins_r; ins_up_nxt = ins_up_r; out_d_nxt = out_d_r;
    out_v_nxt = out_v_r && !out_tready;
    we = 1'b0; waddr = i_r[IW-1:0]; wdata = ins_r; raddr = i_r[IW-1:0];
    {rlen_c, rlen} = 65'd0;
    unique case (state_r)
      art_pkg::S_IDLE: begin
        if (in_tvalid && in_tready) begin
          req_nxt = in_tdata[1:0];
          b_nxt = in_tdata[65:2];
          len_nxt = in_tdata[129:66];
          kind_nxt = in_tdata[130];
          reg_nxt = in_tdata[130] ? in_tdata[162:131] : 32'd0;
          e_nxt = in_tdata[65:2] + in_tdata[129:66];
          it_nxt = '0;
          i_nxt = '0;
          if ({1'b0, in_tdata[65:2]} + {1'b0, in_tdata[129:66]} >
              {1'b0, 64'hFFFF_FFFF_FFFF_FFFF}) begin
            out_d_nxt = pack_out(art_pkg::ST_OVERFLOW, 1'b0, 1'b0, '0);
            state_nxt = art_pkg::S_DONE;
          end else if (in_tdata[1:0] == art_pkg::REQ_UNREG) begin
            {rlen_c, rlen} = {1'b0, in_tdata[129:66]} + {1'b0, pmask};
            rlen = rlen & ~pmask;
            if (rlen_c || ({1'b0, rlen} + {1'b0, in_tdata[65:2]} > {1'b0, ~64'd0})) begin
              out_d_nxt = pack_out(art_pkg::ST_OVERFLOW, 1'b0, 1'b0, '0);
              state_nxt = art_pkg::S_DONE;
            end else begin
              len_nxt = rlen;
              e_nxt = in_tdata[65:2] + rlen;
              state_nxt = art_pkg::S_LOOK;
            end
          end else begin
            state_nxt = art_pkg::S_LOOK;
          end
        end
      end
      // issue read of entry i, or finish the scan
      art_pkg::S_LOOK: begin
        if (i_r >= cnt_r) begin
          k_nxt = '1;  // marks no hit
          state_nxt = art_pkg::S_DECIDE;
        end else begin
          state_nxt = art_pkg::S_LOOK_W;
        end
      end
      art_pkg::S_LOOK_W: begin
        if (hit) begin
          k_nxt = i_r; ent_nxt = rdata; state_nxt = art_pkg::S_DECIDE;
        end else if (past) begin
          k_nxt = '1; state_nxt = art_pkg::S_DECIDE;
        end else begin
          i_nxt = i_r + 1'b1; state_nxt = art_pkg::S_LOOK;
        end
      end
      art_pkg::S_DECIDE: begin
        state_nxt = art_pkg::S_DONE;
        i_nxt = '0;
        it_nxt = it_r + 1'b1;
        unique case (req_r)
          art_pkg::REQ_REG: begin
            if (k_r != '1) out_d_nxt = pack_out(art_pkg::ST_OVERLAP, 1'b0, 1'b0, '0);
            else if (cnt_r >= CW'(art_pkg::MAX_RANGES))
              out_d_nxt = pack_out(art_pkg::ST_FULL, 1'b0, 1'b0, '0);
            else begin
              out_d_nxt = pack_out(art_pkg::ST_OK, 1'b0, 1'b0, '0);
              ins_nxt = '{base: b_r, last: e_r, kind: kind_r, region: reg_r};
              tail_nxt = 1'b0;
              i_nxt = cnt_r;
              state_nxt = art_pkg::S_INS_RD;
            end
          end
          art_pkg::REQ_FIND: begin
            if (k_r != '1) out_d_nxt = pack_out(art_pkg::ST_OK, 1'b0, 1'b1, ent_r);
            else out_d_nxt = pack_out(art_pkg::ST_OK, 1'b0, 1'b0, '0);
          end
          art_pkg::REQ_COVER: begin
            if (k_r == '1 || ent_r.base > b_r || it_r > art_pkg::ITER_W'(art_pkg::ITER_LIMIT))
              out_d_nxt = pack_out(art_pkg::ST_OK, 1'b0, 1'b0, '0);
            else begin
              rlen = ent_r.last - b_r;
              if (rlen > len_r) rlen = len_r;
              if (len_r == rlen) out_d_nxt = pack_out(art_pkg::ST_OK, 1'b1, 1'b0, '0);
              else begin
                len_nxt = len_r - rlen;
                b_nxt = b_r + rlen;
                e_nxt = b_r + len_r;
                state_nxt = art_pkg::S_LOOK;
              end
            end
          end
          default: begin
            out_d_nxt = pack_out(art_pkg::ST_OK, 1'b0, 1'b0, '0);
            if (k_r != '1 && it_r <= art_pkg::ITER_W'(art_pkg::ITER_LIMIT)) begin
              if (b_r == e_r || (b_r & amask) != 0 || (e_r & amask) != 0)
                out_d_nxt = pack_out(art_pkg::ST_CUT, 1'b0, 1'b0, '0);
              else if (b_r > ent_r.base && e_r < ent_r.last &&
                       cnt_r >= CW'(art_pkg::MAX_RANGES))
                out_d_nxt = pack_out(art_pkg::ST_FULL, 1'b0, 1'b0, '0);
              else begin
                // remove slot k by shifting down
                i_nxt = k_r;
                ins_up_nxt = 1'b0;
                state_nxt = art_pkg::S_SHIFT_RD;
              end
            end
          end
        endcase
      end
      // remove: copy entry i+1 into i
      art_pkg::S_SHIFT_RD: begin
        if (i_r + 1'b1 >= cnt_r) begin
          cnt_nxt = cnt_r - 1'b1;
          tail_nxt = e_r < ent_r.last;
          if (b_r > ent_r.base) begin
            ins_nxt = '{base: ent_r.base, last: b_r, kind: ent_r.kind, region: ent_r.region};
            i_nxt = cnt_r - 1'b1;
            state_nxt = art_pkg::S_INS_RD;
          end else if (e_r < ent_r.last) begin
            ins_nxt = '{base: e_r, last: ent_r.last, kind: ent_r.kind, region: ent_r.region};
            tail_nxt = 1'b0;
            i_nxt = cnt_r - 1'b1;
            state_nxt = art_pkg::S_INS_RD;
          end else begin
            i_nxt = '0;
            state_nxt = art_pkg::S_LOOK;
          end
        end else begin
          raddr = IW'(i_r + 1'b1);
          state_nxt = art_pkg::S_SHIFT_WR;
        end
      end
      art_pkg::S_SHIFT_WR: begin
        we = 1'b1; wdata = rdata;
        i_nxt = i_r + 1'b1;
        state_nxt = art_pkg::S_SHIFT_RD;
      end
      // insert: walk down from slot i, moving larger bases up
      art_pkg::S_INS_RD: begin
        if (i_r == '0) begin
          we = 1'b1; wdata = ins_r;
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = art_pkg::S_INS_WR;
        end else begin
          raddr = IW'(i_r - 1'b1);
          state_nxt = art_pkg::S_INS_WR;
          ins_up_nxt = 1'b1;
        end
      end
      art_pkg::S_INS_WR: begin
        if (ins_up_r && rdata.base > ins_r.base) begin
          we = 1'b1; wdata = rdata;
          i_nxt = i_r - 1'b1;
          ins_up_nxt = 1'b0;
          state_nxt = art_pkg::S_INS_RD;
        end else begin
          if (ins_up_r) begin
            we = 1'b1; wdata = ins_r;
            cnt_nxt = cnt_r + 1'b1;
          end
          ins_up_nxt = 1'b0;
          if (tail_r) begin
            ins_nxt = '{base: e_r, last: ent_r.last, kind: ent_r.kind, region: ent_r.region};
            tail_nxt = 1'b0;
            i_nxt = cnt_r + CW'(ins_up_r);
            state_nxt = art_pkg::S_INS_RD;
          end else if (req_r == art_pkg::REQ_UNREG) begin
            i_nxt = '0;
            state_nxt = art_pkg::S_LOOK;
          end else begin
            state_nxt = art_pkg::S_DONE;
          end
        end
      end
      art_pkg::S_DONE: begin
        out_v_nxt = 1'b1;
        state_nxt = art_pkg::S_IDLE;
      end
      default: state_nxt = art_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= art_pkg::S_IDLE;
      cnt_r <= '0;
      out_v_r <= 1'b0;
      page_r <= 5'd12;
      align_r <= 5'd12;
      ins_up_r <= 1'b0;
      tail_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_v_r <= out_v_nxt;
      ins_up_r <= ins_up_nxt;
      tail_r <= tail_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          art_pkg::CFG_PAGE:  page_r  <= cfg_data;
          art_pkg::CFG_ALIGN: align_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt; b_r <= b_nxt; e_r <= e_nxt; len_r <= len_nxt;
    kind_r <= kind_nxt; reg_r <= reg_nxt; i_r <= i_nxt; k_r <= k_nxt;
    it_r <= it_nxt; ent_r <= ent_nxt; ins_r <= ins_nxt; out_d_r <= out_d_nxt;
  end

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(art_pkg::MAX_RANGES)) else $error("count above table size");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready |=> $stable(out_d_r)) else $error("result changed under stall");
  a_noacc: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !in_tready) else $error("request taken with result pending");
`endif

endmodule

// File: sv/art_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// art_ram
// Entry memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module art_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [art_pkg::IDX_W-1:0]  waddr,
  input  art_pkg::entry_t            wdata,
  input  logic [art_pkg::IDX_W-1:0]  raddr,
  output art_pkg::entry_t            rdata
);

  art_pkg::entry_t mem [art_pkg::MAX_RANGES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
